>>> src/plr_pkg.sv
// Shared types, constants and command structures for the polyline resampler.
package plr_pkg;

    localparam int MaxSamples = 62;
    localparam int CntW       = 6;
    localparam int SqW        = 35;
    localparam int LenW       = 18;
    localparam int DW         = 17;

    localparam logic [15:0] StepReset = 16'd90;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_SQRT  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_FINAL = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic sq_step;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic emit_start;
        logic emit_step;
        logic final_out;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic fin;
        logic sq_done;
        logic sqrt_done;
        logic div_done;
        logic emit_last;
        logic out_busy;
    } sts_t;

endpackage

>>> src/plr_ctrl.sv
// Controller state machine of the polyline resampler.
module plr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  plr_pkg::sts_t sts,
    output plr_pkg::cmd_t cmd
);

    plr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == plr_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            plr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = plr_pkg::S_SQ;
                end
            end
            plr_pkg::S_SQ:
            begin
                if (!sts.have_prev)
                begin
                    state_next = sts.fin ? plr_pkg::S_FINAL : plr_pkg::S_DONE;
                end
                else if (sts.sq_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next = plr_pkg::S_SQRT;
                end
                else
                begin
                    cmd.sq_step = 1'b1;
                end
            end
            plr_pkg::S_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = plr_pkg::S_DIV;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            plr_pkg::S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.emit_start = 1'b1;
                    state_next = plr_pkg::S_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            plr_pkg::S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit_step = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = sts.fin ? plr_pkg::S_FINAL : plr_pkg::S_DONE;
                    end
                end
            end
            plr_pkg::S_FINAL:
            begin
                if (!sts.out_busy)
                begin
                    cmd.final_out = 1'b1;
                    state_next = plr_pkg::S_DONE;
                end
            end
            plr_pkg::S_DONE:
            begin
                cmd.commit = 1'b1;
                state_next = plr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = plr_pkg::S_IDLE;
            end
        endcase
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> !sts.out_busy)
        else $error("emit into a full output register");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == plr_pkg::S_SQ)
        else $error("load did not start work");

endmodule

>>> src/plr_dp.sv
// Datapath of the polyline resampler: squared length, root, divide, interpolation.
module plr_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [15:0]   step_length,
    input  logic [48:0]   in_data,
    input  plr_pkg::cmd_t cmd,
    output plr_pkg::sts_t sts,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [49:0]   out_data
);

    logic signed [15:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] cx_reg, cy_reg, cz_reg;
    logic               fin_reg, have_prev_reg;
    logic signed [plr_pkg::DW-1:0] dx_reg, dy_reg, dz_reg;
    logic [plr_pkg::SqW-1:0]  sq_reg, rem_reg;
    logic [1:0]               sq_cnt_reg;
    logic [plr_pkg::LenW-1:0] root_reg;
    logic [4:0]               sqrt_cnt_reg;
    logic [plr_pkg::LenW-1:0] quo_reg;
    logic [16:0]              drem_reg;
    logic [4:0]               div_cnt_reg;
    logic [15:0]              step_reg;
    logic [plr_pkg::CntW-1:0] n_reg, j_reg;
    logic signed [plr_pkg::DW-1:0] ax_reg, ay_reg, az_reg;
    logic [plr_pkg::CntW-1:0] rx_reg, ry_reg, rz_reg;
    logic                     out_valid_reg;
    logic [49:0]              out_data_reg;

    logic signed [plr_pkg::DW-1:0] dsel;
    logic [33:0]               dsq;
    logic [plr_pkg::SqW+1:0]   trial;
    logic [plr_pkg::SqW+1:0]   rem_sh;
    logic [17:0]               dtrial;
    logic [plr_pkg::LenW-1:0]  nq;
    logic                      out_busy;

    assign out_busy = out_valid_reg && !out_ready;

    // The squared length is below 2^34, so the root works on the pairs from bit 33 down.
    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    dsel = dx_reg;
            2'd1:    dsel = dy_reg;
            default: dsel = dz_reg;
        endcase
        dsq = 34'($signed(dsel) * $signed(dsel));
        rem_sh = {rem_reg, sq_reg[plr_pkg::SqW-2 -: 2]};
        trial  = (plr_pkg::SqW+2)'({root_reg, 2'b01});
        dtrial = {drem_reg, quo_reg[plr_pkg::LenW-1]};
        if (quo_reg == '0)
        begin
            nq = plr_pkg::LenW'(1);
        end
        else if (quo_reg > plr_pkg::LenW'(plr_pkg::MaxSamples))
        begin
            nq = plr_pkg::LenW'(plr_pkg::MaxSamples);
        end
        else
        begin
            nq = quo_reg;
        end
    end

    logic signed [plr_pkg::DW-1:0] qx_reg, qy_reg, qz_reg;
    logic [plr_pkg::CntW-1:0]      mx_reg, my_reg, mz_reg;
    logic [plr_pkg::DW+1:0]        qrem_reg;
    logic [plr_pkg::DW:0]          qquo_reg;
    logic [4:0]                    qbit_reg;
    logic [1:0]                    qax_reg;

    logic [plr_pkg::CntW:0]   rsum_x, rsum_y, rsum_z;
    logic                     cy_x, cy_y, cy_z;

    // Offset accumulators keep floor(d*j/n) as quotient plus remainder.
    always_comb
    begin
        rsum_x = {1'b0, rx_reg} + {1'b0, mx_reg};
        rsum_y = {1'b0, ry_reg} + {1'b0, my_reg};
        rsum_z = {1'b0, rz_reg} + {1'b0, mz_reg};
        cy_x = rsum_x >= {1'b0, n_reg};
        cy_y = rsum_y >= {1'b0, n_reg};
        cy_z = rsum_z >= {1'b0, n_reg};
    end

    logic [plr_pkg::DW-1:0] absd;
    logic [plr_pkg::DW:0]   qt;

    always_comb
    begin
        case (qax_reg)
            2'd0:    absd = dx_reg[plr_pkg::DW-1] ? plr_pkg::DW'(-dx_reg) : dx_reg;
            2'd1:    absd = dy_reg[plr_pkg::DW-1] ? plr_pkg::DW'(-dy_reg) : dy_reg;
            default: absd = dz_reg[plr_pkg::DW-1] ? plr_pkg::DW'(-dz_reg) : dz_reg;
        endcase
        qt = {qrem_reg[plr_pkg::DW-1:0], absd[qbit_reg]};
    end

    logic                          qneg;
    logic signed [plr_pkg::DW-1:0] qfloor;
    logic [plr_pkg::CntW-1:0]      mfloor;
    logic [plr_pkg::DW:0]          qsub;
    logic [plr_pkg::DW-1:0]        qnext;
    logic [plr_pkg::CntW-1:0]      rnext;

    always_comb
    begin
        qneg = (qax_reg == 2'd0) ? dx_reg[plr_pkg::DW-1] :
               (qax_reg == 2'd1) ? dy_reg[plr_pkg::DW-1] : dz_reg[plr_pkg::DW-1];
        qsub = qt - {{(plr_pkg::DW+1-plr_pkg::CntW){1'b0}}, n_reg};
        if (!qsub[plr_pkg::DW])
        begin
            rnext = plr_pkg::CntW'(qsub);
            qnext = {qquo_reg[plr_pkg::DW-2:0], 1'b1};
        end
        else
        begin
            rnext = plr_pkg::CntW'(qt);
            qnext = {qquo_reg[plr_pkg::DW-2:0], 1'b0};
        end
        if (qneg && rnext != '0)
        begin
            qfloor = plr_pkg::DW'(-$signed({1'b0, qnext}) - 1);
            mfloor = n_reg - rnext;
        end
        else
        begin
            qfloor = qneg ? plr_pkg::DW'(-$signed({1'b0, qnext})) : $signed(qnext);
            mfloor = rnext;
        end
    end

    logic qdiv_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            qdiv_busy_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit_step || cmd.final_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                cx_reg  <= in_data[15:0];
                cy_reg  <= in_data[31:16];
                cz_reg  <= in_data[47:32];
                fin_reg <= in_data[48];
                dx_reg  <= plr_pkg::DW'($signed(in_data[15:0]))  - plr_pkg::DW'(px_reg);
                dy_reg  <= plr_pkg::DW'($signed(in_data[31:16])) - plr_pkg::DW'(py_reg);
                dz_reg  <= plr_pkg::DW'($signed(in_data[47:32])) - plr_pkg::DW'(pz_reg);
                sq_reg  <= '0;
                sq_cnt_reg <= '0;
                step_reg <= (step_length == '0) ? 16'd1 : step_length;
            end
            if (cmd.sq_step)
            begin
                sq_reg <= sq_reg + plr_pkg::SqW'(dsq);
                sq_cnt_reg <= sq_cnt_reg + 2'd1;
            end
            if (cmd.sqrt_start)
            begin
                rem_reg  <= '0;
                root_reg <= '0;
                sqrt_cnt_reg <= '0;
            end
            if (cmd.sqrt_step)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= plr_pkg::SqW'(rem_sh - trial);
                    root_reg <= {root_reg[plr_pkg::LenW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= plr_pkg::SqW'(rem_sh);
                    root_reg <= {root_reg[plr_pkg::LenW-2:0], 1'b0};
                end
                sq_reg <= {sq_reg[plr_pkg::SqW-3:0], 2'b00};
                sqrt_cnt_reg <= sqrt_cnt_reg + 5'd1;
            end
            if (cmd.div_start)
            begin
                quo_reg  <= root_reg;
                drem_reg <= '0;
                div_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                if (dtrial >= {2'b00, step_reg})
                begin
                    drem_reg <= 17'(dtrial - {2'b00, step_reg});
                    quo_reg  <= {quo_reg[plr_pkg::LenW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dtrial[16:0];
                    quo_reg  <= {quo_reg[plr_pkg::LenW-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            if (cmd.emit_start)
            begin
                n_reg <= plr_pkg::CntW'(nq);
                j_reg <= '0;
                ax_reg <= '0;
                ay_reg <= '0;
                az_reg <= '0;
                rx_reg <= '0;
                ry_reg <= '0;
                rz_reg <= '0;
                qdiv_busy_reg <= 1'b1;
                qax_reg  <= '0;
                qbit_reg <= 5'(plr_pkg::DW - 1);
                qrem_reg <= '0;
                qquo_reg <= '0;
            end
            if (qdiv_busy_reg)
            begin
                if (qbit_reg == '0)
                begin
                    case (qax_reg)
                        2'd0:
                        begin
                            qx_reg <= qfloor;
                            mx_reg <= mfloor;
                        end
                        2'd1:
                        begin
                            qy_reg <= qfloor;
                            my_reg <= mfloor;
                        end
                        default:
                        begin
                            qz_reg <= qfloor;
                            mz_reg <= mfloor;
                        end
                    endcase
                    qrem_reg <= '0;
                    qquo_reg <= '0;
                    qbit_reg <= 5'(plr_pkg::DW - 1);
                    if (qax_reg == 2'd2)
                    begin
                        qdiv_busy_reg <= 1'b0;
                    end
                    qax_reg <= qax_reg + 2'd1;
                end
                else
                begin
                    qrem_reg <= {{(plr_pkg::DW+2-plr_pkg::CntW){1'b0}}, rnext};
                    qquo_reg <= {1'b0, qnext};
                    qbit_reg <= qbit_reg - 5'd1;
                end
            end
            if (cmd.emit_step)
            begin
                out_data_reg <= {1'b0, (j_reg == n_reg) && !fin_reg,
                                 16'(pz_reg + 16'(az_reg)),
                                 16'(py_reg + 16'(ay_reg)),
                                 16'(px_reg + 16'(ax_reg))};
                j_reg <= j_reg + plr_pkg::CntW'(1);
                ax_reg <= ax_reg + qx_reg + plr_pkg::DW'(cy_x);
                ay_reg <= ay_reg + qy_reg + plr_pkg::DW'(cy_y);
                az_reg <= az_reg + qz_reg + plr_pkg::DW'(cy_z);
                rx_reg <= cy_x ? plr_pkg::CntW'(rsum_x - {1'b0, n_reg}) : plr_pkg::CntW'(rsum_x);
                ry_reg <= cy_y ? plr_pkg::CntW'(rsum_y - {1'b0, n_reg}) : plr_pkg::CntW'(rsum_y);
                rz_reg <= cy_z ? plr_pkg::CntW'(rsum_z - {1'b0, n_reg}) : plr_pkg::CntW'(rsum_z);
            end
            if (cmd.final_out)
            begin
                out_data_reg <= {2'b11, cz_reg, cy_reg, cx_reg};
            end
            if (cmd.commit)
            begin
                px_reg <= cx_reg;
                py_reg <= cy_reg;
                pz_reg <= cz_reg;
                have_prev_reg <= !fin_reg;
            end
        end
    end

    assign sts.have_prev = have_prev_reg;
    assign sts.fin       = fin_reg;
    assign sts.sq_done   = (sq_cnt_reg == 2'd3);
    assign sts.sqrt_done = (sqrt_cnt_reg == 5'(plr_pkg::LenW - 1));
    assign sts.div_done  = (div_cnt_reg == 5'(plr_pkg::LenW));
    assign sts.emit_last = (j_reg == n_reg);
    assign sts.out_busy  = out_busy || qdiv_busy_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_busy |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result changed");
    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> (n_reg != '0 && j_reg <= n_reg))
        else $error("sample index out of range");
    a_no_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        qdiv_busy_reg |-> !cmd.emit_step)
        else $error("emit before offsets ready");

endmodule

>>> src/polyline_resampler_top.sv
// Top level of the polyline resampler: configuration register, controller and datapath.
// A waypoint is taken while the block is idle; the segment from the previous waypoint then runs
// the squared length, the bit-serial square root, the restoring divide by the step and three
// bit-serial offset divides by the sample count, followed by one emitted point per cycle (n+1,
// up to 63, plus one for a final waypoint) when the output is taken at once, and then stores
// the waypoint. The first waypoint of a path skips these steps and is only stored, after being
// sent out when it is also final. A stalled output holds the block for as long as the stall
// lasts, and no new item is taken until the current one has finished.
module polyline_resampler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // way_x, way_y, way_z
    input  logic        s_axis_tlast,  // final_waypoint
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // pt_x, pt_y, pt_z
    output logic        m_axis_tlast,  // run_last
    output logic        m_axis_tuser   // path_end
);

    logic [15:0]   step_reg;
    plr_pkg::cmd_t cmd;
    plr_pkg::sts_t sts;
    logic [49:0]   out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= plr_pkg::StepReset;
        end
        else if (cfg_wr_en)
        begin
            step_reg <= cfg_wr_data;
        end
    end

    plr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_length (step_reg),
        .in_data     ({s_axis_tlast, s_axis_tdata}),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (out_data)
    );

    assign m_axis_tdata = out_data[47:0];
    assign m_axis_tlast = out_data[48];
    assign m_axis_tuser = out_data[49];

endmodule
